### rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/clr_pkg.sv
`default_nettype none
package clr_pkg;

    // register indexes on the config port
    localparam logic [1:0] CfgClipEps   = 2'd0;
    localparam logic [1:0] CfgKlWeight  = 2'd1;
    localparam logic [1:0] CfgUseRef    = 2'd2;
    localparam logic [15:0] ClipEpsReset = 16'd13107;

    // token count limit
    localparam logic [20:0] MaxTokens = 21'd1048576;

    // exp table geometry
    localparam int ExpLog2    = 8;
    localparam int ExpEntries = 1 << ExpLog2;
    localparam int IdxW       = ExpLog2 + 1;
    localparam int FracShift  = 20 - ExpLog2;

    // log-ratio clamp, +-8.0 in Q8.16
    localparam logic signed [24:0] DClamp = 25'sd524288;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);

    typedef logic [31:0] exp_tab_t [0:ExpEntries];

    // one classified token between front and back
    typedef struct packed {
        logic [20:0]        ofs;      // clamped log-ratio plus 8.0
        logic signed [23:0] adv;
        logic signed [24:0] kl_diff;  // policy minus reference
        logic               last;
    } clr_item_t;

    // signed quotient truncated toward zero, shift-subtract on magnitudes
    function automatic longint div_trunc(input longint dvd, input longint dvs);
        logic [63:0] n_mag;
        logic [63:0] d_mag;
        logic [63:0] q;
        logic [64:0] r;
        n_mag = (dvd < 0) ? 64'(-dvd) : 64'(dvd);
        d_mag = (dvs < 0) ? 64'(-dvs) : 64'(dvs);
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n_mag[b]};
            if (r >= {1'b0, d_mag}) begin
                r    = r - {1'b0, d_mag};
                q[b] = 1'b1;
            end
        end
        return ((dvd < 0) != (dvs < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // exp(-8 + 16k/E) in Q16.16 from a truncated Taylor series in Q30
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t t;
        longint num;
        longint term;
        longint sum;
        for (int k = 0; k <= ExpEntries; k++) begin
            num  = 16 * longint'(k) - 8 * longint'(ExpEntries);
            term = longint'(1) <<< 30;
            sum  = term;
            for (int n = 1; n <= 80; n++) begin
                term = div_trunc(term * num, longint'(ExpEntries) * longint'(n));
                sum  = sum + term;
            end
            t[k] = (sum > 0) ? 32'((sum + 8192) >>> 14) : 32'd0;
        end
        return t;
    endfunction

    localparam exp_tab_t ExpTab = build_exp_tab();

endpackage
`default_nettype wire

### rtl/core/clr_front.sv
`default_nettype none
module clr_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [95:0]        s_tdata,
    input  wire logic               s_tlast,
    output clr_pkg::clr_item_t      item,
    output logic                    item_valid,
    input  wire logic               item_ready
);
    import clr_pkg::*;

    logic signed [23:0] pol;
    logic signed [23:0] old;
    logic signed [23:0] refp;
    logic signed [24:0] d;
    logic signed [24:0] d_cl;
    logic signed [24:0] ofs_wide;
    clr_item_t          item_next;
    clr_item_t          item_reg;
    logic               valid_reg;

    // field unpack
    assign pol  = s_tdata[23:0];
    assign old  = s_tdata[47:24];
    assign refp = s_tdata[71:48];

    // clamp log-ratio and shift into table range
    always_comb begin
        d = {pol[23], pol} - {old[23], old};
        if (d > DClamp) begin
            d_cl = DClamp;
        end else if (d < -DClamp) begin
            d_cl = -DClamp;
        end else begin
            d_cl = d;
        end
        ofs_wide          = d_cl + DClamp;
        item_next.ofs     = ofs_wide[20:0];
        item_next.adv     = s_tdata[95:72];
        item_next.kl_diff = {pol[23], pol} - {refp[23], refp};
        item_next.last    = s_tlast;
    end

    assign s_tready   = !valid_reg || item_ready;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    // one-beat holding stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
            item_reg  <= item_next;
        end else if (item_ready) begin
            valid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### rtl/core/clr_fifo.sv
`default_nettype none
module clr_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  clr_pkg::clr_item_t      din,
    output logic                    full,
    input  wire logic               pop,
    output clr_pkg::clr_item_t      dout,
    output logic                    empty
);
    import clr_pkg::*;

    clr_item_t            mem_reg [0:FifoDepth-1];
    logic [FifoPtrW-1:0]  wr_ptr_reg;
    logic [FifoPtrW-1:0]  rd_ptr_reg;
    logic [FifoPtrW:0]    count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == (FifoPtrW+1)'(FifoDepth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/clr_div.sv
`default_nettype none
module clr_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [20:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    logic [63:0] dvd_reg;
    logic [20:0] dsr_reg;
    logic [20:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [21:0] rem_sh;
    logic [21:0] rem_sub;

    // one restoring step per cycle, quotient shifts into the dividend
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[63]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                if (!rem_sub[21]) begin
                    rem_reg <= rem_sub[20:0];
                    dvd_reg <= {dvd_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[20:0];
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/clr_back.sv
`default_nettype none
module clr_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  clr_pkg::clr_item_t      item,
    input  wire logic               item_empty,
    output logic                    item_pop,
    input  wire logic [15:0]        clip_epsilon,
    input  wire logic [23:0]        kl_weight,
    input  wire logic               use_reference,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [55:0]             m_tdata
);
    import clr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_RATIO, ST_PROD, ST_ACC, ST_DSTART, ST_DIV, ST_OUT
    } state_t;

    state_t             state_reg;
    clr_item_t          cur_reg;
    logic [27:0]        base_reg;
    logic [27:0]        step_reg;
    logic [27:0]        ratio_reg;
    logic [27:0]        clipped_reg;
    logic signed [63:0] o1_reg;
    logic signed [63:0] o2_reg;
    logic signed [63:0] kl_reg;
    logic signed [63:0] sum_reg;
    logic [20:0]        count_reg;
    logic               neg_reg;
    logic [31:0]        mean_reg;
    logic               out_valid_reg;
    logic [55:0]        out_data_reg;

    logic [IdxW-1:0]    idx;
    logic [IdxW-1:0]    idx_p1;
    logic [19:0]        frac;
    logic [31:0]        tab_a;
    logic [31:0]        tab_b;
    logic [51:0]        step_prod;
    logic [27:0]        ratio_next;
    logic [16:0]        lo;
    logic [16:0]        hi;
    logic signed [52:0] o1_prod;
    logic signed [52:0] o2_prod;
    logic signed [49:0] kl_prod;
    logic signed [63:0] loss;
    logic signed [63:0] loss_rnd;
    logic [63:0]        mag;
    logic [20:0]        divc;
    logic [63:0]        dividend;
    logic               div_done;
    logic [63:0]        quot;
    logic [31:0]        mean_next;

    // table lookup with linear interpolation
    always_comb begin
        idx    = cur_reg.ofs[20:FracShift];
        idx_p1 = idx + 1'b1;
        frac   = {cur_reg.ofs[FracShift-1:0], ExpLog2'(0)};
        tab_a  = ExpTab[idx];
        tab_b  = ExpTab[idx_p1];
        step_prod = 52'(tab_b - tab_a) * 52'(frac);
    end

    // ratio and clip window
    always_comb begin
        ratio_next = base_reg + step_reg;
        lo = 17'd65536 - {1'b0, clip_epsilon};
        hi = 17'd65536 + {1'b0, clip_epsilon};
    end

    // products of the surrogate and the penalty
    always_comb begin
        o1_prod = $signed({1'b0, ratio_reg}) * cur_reg.adv;
        o2_prod = $signed({1'b0, clipped_reg}) * cur_reg.adv;
        kl_prod = $signed({1'b0, (use_reference ? kl_weight : 24'd0)}) * cur_reg.kl_diff;
    end

    // token loss rounded to Q16.16
    always_comb begin
        loss     = ((o1_reg < o2_reg) ? -o1_reg : -o2_reg) + kl_reg;
        loss_rnd = (loss + 64'sd32768) >>> 16;
    end

    // rounded mean setup
    always_comb begin
        mag      = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
        divc     = (count_reg == '0) ? 21'd1 : count_reg;
        dividend = mag + 64'(divc >> 1);
    end

    // saturate the signed mean
    always_comb begin
        if (!neg_reg) begin
            mean_next = (quot > 64'd2147483647) ? 32'h7FFF_FFFF : quot[31:0];
        end else begin
            mean_next = (quot > 64'd2147483648) ? 32'h8000_0000 : 32'(-quot);
        end
    end

    clr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DSTART),
        .dividend (dividend),
        .divisor  (divc),
        .done     (div_done),
        .quotient (quot)
    );

    assign item_pop = (state_reg == ST_IDLE) && !item_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // result beat: load on the batch end, drop once taken
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!item_empty) begin
                        cur_reg   <= item;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (idx[IdxW-1]) begin
                        base_reg <= ExpTab[ExpEntries][27:0];
                        step_reg <= '0;
                    end else begin
                        base_reg <= tab_a[27:0];
                        step_reg <= (tab_b > tab_a) ? step_prod[47:20] : 28'd0;
                    end
                    state_reg <= ST_RATIO;
                end
                ST_RATIO: begin
                    ratio_reg <= ratio_next;
                    if (ratio_next < 28'(lo)) begin
                        clipped_reg <= 28'(lo);
                    end else if (ratio_next > 28'(hi)) begin
                        clipped_reg <= 28'(hi);
                    end else begin
                        clipped_reg <= ratio_next;
                    end
                    state_reg <= ST_PROD;
                end
                ST_PROD: begin
                    o1_reg    <= 64'(o1_prod);
                    o2_reg    <= 64'(o2_prod);
                    kl_reg    <= 64'(kl_prod);
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (count_reg < MaxTokens) begin
                        sum_reg   <= sum_reg + loss_rnd;
                        count_reg <= count_reg + 21'd1;
                    end
                    state_reg <= cur_reg.last ? ST_DSTART : ST_IDLE;
                end
                ST_DSTART: begin
                    neg_reg   <= sum_reg[63];
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        mean_reg  <= mean_next;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_data_reg  <= {3'b000, count_reg, mean_reg};
                        sum_reg       <= '0;
                        count_reg     <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/clipped_ratio_loss_accumulator.sv
// Clipped-ratio loss accumulator.
// Input stream (s_): one token per beat, tdata carries the policy, old and
// reference log-probabilities and the advantage; tlast marks the batch end.
// Output stream (m_): one beat per batch with the rounded mean loss and the
// token count, issued after the token carrying tlast.
// Config port: cfg_wr_en writes cfg_wr_data to register cfg_addr
// (0 clip epsilon, 1 kl weight, 2 use reference); write only while idle.
// The back-end sequencer walks each token through table lookup, interpolation,
// clipping, products and accumulation, and pops the next token only from idle.
// A four-entry queue and a front holding stage absorb bursts.
// A token beat passes the front holding stage and the queue before the back
// end sums it; a batch end adds the bit-serial mean division.
// Reset clears the sums, the count and the queue and returns the config
// registers to their defaults.
// When m_tready is low the result holds in the output register; the back end
// keeps working on the next batch and stops only on its own batch end.
`default_nettype none
module clipped_ratio_loss_accumulator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,  // policy_logprob, old_logprob, ref_logprob, advantage
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // mean_loss, tokens_counted, zero pad
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wr_data
);
    import clr_pkg::*;

    logic [15:0] clip_hw_reg;
    logic [23:0] kl_weight_reg;
    logic        use_ref_reg;
    clr_item_t   front_item;
    logic        front_valid;
    logic        fifo_full;
    clr_item_t   fifo_dout;
    logic        fifo_empty;
    logic        fifo_pop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_hw_reg   <= ClipEpsReset;
            kl_weight_reg <= '0;
            use_ref_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CfgClipEps:  clip_hw_reg   <= cfg_wr_data[15:0];
                CfgKlWeight: kl_weight_reg <= cfg_wr_data;
                CfgUseRef:   use_ref_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    clr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (!fifo_full)
    );

    clr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_valid),
        .din     (front_item),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .dout    (fifo_dout),
        .empty   (fifo_empty)
    );

    clr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item          (fifo_dout),
        .item_empty    (fifo_empty),
        .item_pop      (fifo_pop),
        .clip_epsilon  (clip_hw_reg),
        .kl_weight     (kl_weight_reg),
        .use_reference (use_ref_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );
endmodule
`default_nettype wire

### rtl/core/clr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module clr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    import clr_pkg::*;

    // a stalled result beat stays up
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // every batch averages at least one token
    `ASSERT_IMPLY(a_count_nonzero, aclk, aresetn, m_tvalid, m_tdata[52:32] != 21'd0)
    // count never passes the limit
    `ASSERT_IMPLY(a_count_bound, aclk, aresetn, m_tvalid, m_tdata[52:32] <= MaxTokens)
    // pad bits stay clear
    `ASSERT_IMPLY(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[55:53] == 3'b000)
endmodule

bind clipped_ratio_loss_accumulator clr_checker u_clr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
